@@ src/tlsm_pkg.sv @@
// Shared types and constants for the two-level sector map with LFU table cache.
`timescale 1ns / 1ps

package tlsm_pkg;

    localparam int DIR_DEPTH  = 1024;
    localparam int CACHE_WAYS = 16;
    localparam int DIR_AW     = $clog2(DIR_DEPTH);
    localparam int WAY_W      = $clog2(CACHE_WAYS);

    localparam int ADDR_W   = 40;
    localparam int SLOT_W   = 10;
    localparam int WORD_W   = 32;
    localparam int ENTRY_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [WORD_W-1:0] COUNT_TOP = 32'hffff_ffff;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_SHIFT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_ENTRIES    = 2'd2;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    typedef logic [DIR_AW-1:0] dir_addr_t;
    typedef logic [WAY_W-1:0]  way_t;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_BEYOND  = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_HIT     = 3'd3,
        ST_MISS    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_SCAN,
        S_OUT
    } state_t;

endpackage

@@ src/tlsm_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module tlsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/two_level_sector_map_lfu_cache_unit.sv @@
// Top level: directory load, two-level sector translation and LFU table-id cache.
// One item in flight at a time. A directory load goes from the accept state to the
// result beat. A translation steps through accept, lookup (slot shift and
// directory read), check (entry shift), then a scan of the cache ways in turn
// by the single shared compare unit, up to CACHE_WAYS (16) on a miss, then the
// result beat; the scan is skipped for an out-of-range slot or an empty directory
// word and ends early on a hit, and the result beat is held until m_tready. No
// clearing pass after reset; the directory is undefined until loaded.
`timescale 1ns / 1ps

module two_level_sector_map_lfu_cache_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // sector_address[39:0], dir_slot[49:40], dir_word[81:50]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // way[3:0], table_sector[35:4], entry_index[47:36]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_we,
    input  logic [tlsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    tlsm_pkg::state_t  state_reg, state_next;
    tlsm_pkg::status_t status_reg, status_next;

    logic [4:0]  cluster_shift_reg;
    logic [3:0]  l2_shift_reg;
    logic [10:0] l1_entries_reg;

    logic [tlsm_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [tlsm_pkg::WORD_W-1:0]  table_reg, table_next;
    logic [tlsm_pkg::ENTRY_W-1:0] entry_reg, entry_next;
    logic [tlsm_pkg::WORD_W-1:0]  least_reg, least_next;
    tlsm_pkg::way_t idx_reg, idx_next;
    tlsm_pkg::way_t victim_reg, victim_next;
    tlsm_pkg::way_t way_reg, way_next;

    logic [tlsm_pkg::WORD_W-1:0] ids_reg [tlsm_pkg::CACHE_WAYS];
    logic [tlsm_pkg::WORD_W-1:0] ids_next [tlsm_pkg::CACHE_WAYS];
    logic [tlsm_pkg::WORD_W-1:0] cnt_reg [tlsm_pkg::CACHE_WAYS];
    logic [tlsm_pkg::WORD_W-1:0] cnt_next [tlsm_pkg::CACHE_WAYS];

    logic [tlsm_pkg::ADDR_W-1:0] in_addr;
    logic [tlsm_pkg::SLOT_W-1:0] in_slot;
    logic [tlsm_pkg::WORD_W-1:0] in_word;
    logic                        in_beat;

    logic [5:0]                  sh_amt;
    logic [tlsm_pkg::ADDR_W-1:0] sh_out;
    logic [15:0]                 entry_mask;

    logic                        ram_we;
    tlsm_pkg::dir_addr_t         ram_addr;
    logic [tlsm_pkg::WORD_W-1:0] ram_rdata;

    logic                        way_match;
    logic                        way_less;
    logic [tlsm_pkg::WORD_W-1:0] cnt_inc;
    tlsm_pkg::way_t              vic_now;
    logic                        has_data;

    assign in_addr = s_tdata[39:0];
    assign in_slot = s_tdata[49:40];
    assign in_word = s_tdata[81:50];
    assign in_beat = s_tvalid && s_tready;

    // shared shifter: slot in lookup, cluster index in check
    assign sh_amt     = (state_reg == tlsm_pkg::S_LOOKUP) ?
                        (6'(cluster_shift_reg) + 6'(l2_shift_reg)) : 6'(cluster_shift_reg);
    assign sh_out     = addr_reg >> sh_amt;
    assign entry_mask = (16'd1 << l2_shift_reg) - 16'd1;

    assign ram_we   = in_beat && (s_tuser[0] == tlsm_pkg::OP_LOAD) &&
                      (17'(in_slot) < 17'(tlsm_pkg::DIR_DEPTH));
    assign ram_addr = (state_reg == tlsm_pkg::S_LOOKUP) ? tlsm_pkg::dir_addr_t'(sh_out) :
                      tlsm_pkg::dir_addr_t'(in_slot);

    tlsm_ram #(
        .WIDTH (tlsm_pkg::WORD_W),
        .DEPTH (tlsm_pkg::DIR_DEPTH)
    ) u_dir_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .addr    (ram_addr),
        .wr_data (in_word),
        .rd_data (ram_rdata)
    );

    // shared compare unit over one way per cycle
    assign way_match = (ids_reg[idx_reg] == table_reg);
    assign way_less  = (cnt_reg[idx_reg] < least_reg);
    assign cnt_inc   = cnt_reg[idx_reg] + 32'd1;
    assign vic_now   = way_less ? idx_reg : victim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_shift_reg <= 5'd7;
            l2_shift_reg      <= 4'd9;
            l1_entries_reg    <= 11'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                tlsm_pkg::CFG_CLUSTER_SHIFT: cluster_shift_reg <= cfg_wdata[4:0];
                tlsm_pkg::CFG_L2_SHIFT:      l2_shift_reg      <= cfg_wdata[3:0];
                tlsm_pkg::CFG_L1_ENTRIES:    l1_entries_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlsm_pkg::S_IDLE;
            for (int i = 0; i < tlsm_pkg::CACHE_WAYS; i++) begin
                ids_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            for (int i = 0; i < tlsm_pkg::CACHE_WAYS; i++) begin
                ids_reg[i] <= ids_next[i];
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        addr_reg   <= addr_next;
        table_reg  <= table_next;
        entry_reg  <= entry_next;
        least_reg  <= least_next;
        idx_reg    <= idx_next;
        victim_reg <= victim_next;
        way_reg    <= way_next;
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        table_next  = table_reg;
        entry_next  = entry_reg;
        least_next  = least_reg;
        idx_next    = idx_reg;
        victim_next = victim_reg;
        way_next    = way_reg;
        for (int i = 0; i < tlsm_pkg::CACHE_WAYS; i++) begin
            ids_next[i] = ids_reg[i];
            cnt_next[i] = cnt_reg[i];
        end
        s_tready = 1'b0;
        m_tvalid = 1'b0;

        case (state_reg)
            tlsm_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (in_beat) begin
                    addr_next = in_addr;
                    if (s_tuser[0] == tlsm_pkg::OP_LOAD) begin
                        status_next = tlsm_pkg::ST_LOADED;
                        state_next  = tlsm_pkg::S_OUT;
                    end else begin
                        state_next = tlsm_pkg::S_LOOKUP;
                    end
                end
            end
            tlsm_pkg::S_LOOKUP: begin
                if ((sh_out < 40'(l1_entries_reg)) &&
                    (sh_out < 40'(tlsm_pkg::DIR_DEPTH))) begin
                    state_next = tlsm_pkg::S_CHECK;
                end else begin
                    status_next = tlsm_pkg::ST_BEYOND;
                    state_next  = tlsm_pkg::S_OUT;
                end
            end
            tlsm_pkg::S_CHECK: begin
                table_next  = ram_rdata;
                entry_next  = tlsm_pkg::ENTRY_W'(sh_out[15:0] & entry_mask);
                idx_next    = '0;
                victim_next = '0;
                least_next  = tlsm_pkg::COUNT_TOP;
                if (ram_rdata == '0) begin
                    status_next = tlsm_pkg::ST_ABSENT;
                    state_next  = tlsm_pkg::S_OUT;
                end else begin
                    state_next = tlsm_pkg::S_SCAN;
                end
            end
            tlsm_pkg::S_SCAN: begin
                if (way_match) begin
                    if (cnt_inc == tlsm_pkg::COUNT_TOP) begin
                        for (int i = 0; i < tlsm_pkg::CACHE_WAYS; i++) begin
                            cnt_next[i] = cnt_reg[i] >> 1;
                        end
                        cnt_next[idx_reg] = cnt_inc >> 1;
                    end else begin
                        cnt_next[idx_reg] = cnt_inc;
                    end
                    status_next = tlsm_pkg::ST_HIT;
                    way_next    = idx_reg;
                    state_next  = tlsm_pkg::S_OUT;
                end else if (idx_reg == tlsm_pkg::way_t'(tlsm_pkg::CACHE_WAYS - 1)) begin
                    ids_next[vic_now] = table_reg;
                    cnt_next[vic_now] = 32'd1;
                    status_next       = tlsm_pkg::ST_MISS;
                    way_next          = vic_now;
                    state_next        = tlsm_pkg::S_OUT;
                end else begin
                    if (way_less) begin
                        least_next = cnt_reg[idx_reg];
                    end
                    victim_next = vic_now;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            tlsm_pkg::S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = tlsm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tlsm_pkg::S_IDLE;
            end
        endcase
    end

    assign has_data = (status_reg == tlsm_pkg::ST_HIT) || (status_reg == tlsm_pkg::ST_MISS);
    assign m_tuser  = status_reg;
    assign m_tdata  = has_data ? {entry_reg, table_reg, 4'(way_reg)} : 48'd0;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output ready together");

    a_beat_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (!m_tvalid && s_tready))
        else $error("result beat repeated");

    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && (s_tuser[0] == tlsm_pkg::OP_LOAD)) |=>
        (m_tvalid && (m_tuser == tlsm_pkg::ST_LOADED)))
        else $error("load did not report loaded");

    a_count_below_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlsm_pkg::S_SCAN) |-> (cnt_reg[idx_reg] != tlsm_pkg::COUNT_TOP))
        else $error("use count saturated");

    a_table_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && has_data) |-> (table_reg != '0))
        else $error("cache result with empty table sector");
`endif

endmodule
